// ----- rtl/core/layer_pixel_blend_core_assert.svh -----
// Assertion macros for the layer pixel blend core.
`ifndef LAYER_PIXEL_BLEND_CORE_ASSERT_SVH
`define LAYER_PIXEL_BLEND_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LPB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LPB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lpb_pkg.sv -----
package lpb_pkg;

   localparam int NUM_LAYERS = 4;

   // channel arithmetic
   localparam logic [7:0]  CH_MAX    = 8'd255;
   localparam logic [7:0]  LERP_BIAS = 8'd127;
   localparam logic [16:0] SAT_LIMIT = 17'd65025;   // 255 * 255

   // blend mode codes
   typedef enum logic [2:0] {
      MODE_ADD   = 3'd0,
      MODE_ALPHA = 3'd1,
      MODE_SUB   = 3'd2,
      MODE_MIX   = 3'd3,
      MODE_MAX   = 3'd4,
      MODE_MIN   = 3'd5
   } mode_type;

   // register indexes
   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_BLEND_MODE   = 2'd0;
   localparam csr_addr_type CSR_LAYER_ENABLE = 2'd1;
   localparam csr_addr_type CSR_MIX_WEIGHT   = 2'd2;

   // register reset values
   localparam logic [2:0]            RST_BLEND_MODE   = 3'd0;
   localparam logic [NUM_LAYERS-1:0] RST_LAYER_ENABLE = 4'hF;
   localparam logic [7:0]            RST_MIX_WEIGHT   = 8'd128;

   // blend controls shared by every step
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] mix_weight;
   } lpb_ctrl_type;

   // per-stage tag traveling with the data
   typedef struct packed {
      logic valid;
      logic have;    // some layer already folded in
   } lpb_tag_type;

endpackage

// ----- rtl/core/lpb_blend_step.sv -----
// One fold step: blends a new layer onto the running pixel.
// Stage A: products and simple results. Stage B: divide by 255 and select.
module lpb_blend_step #(
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  lpb_pkg::lpb_ctrl_type ctrl,
   input  logic                 layer_en,
   input  lpb_pkg::lpb_tag_type  in_tag,
   input  logic [31:0]          in_acc,
   input  logic [31:0]          in_px,
   input  logic [SIDE_W-1:0]    in_side,
   output lpb_pkg::lpb_tag_type  out_tag,
   output logic [31:0]          out_acc,
   output logic [SIDE_W-1:0]    out_side
);
   import lpb_pkg::*;

   // x / 255 saturated at 255; x below 2^17
   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [16:0] t;
      logic [8:0]  q0;
      logic [16:0] m;
      logic [16:0] rem;
      logic [8:0]  q;
      t   = {1'b0, x[15:0]} + {9'b0, x[15:8]};
      q0  = t[16:8];
      m   = {q0, 8'b0} - {8'b0, q0};
      rem = {1'b0, x[15:0]} - m;
      q   = (rem >= 17'd255) ? q0 + 9'd1 : q0;
      if (x >= SAT_LIMIT) begin
         div255 = CH_MAX;
      end else begin
         div255 = q[7:0];
      end
   endfunction

   // stage A
   lpb_tag_type        tag_a_ff, tag_a_in;
   logic [3:0][7:0]    simple_a_ff, simple_a_in;
   logic [3:0]         sel_a_ff, sel_a_in;
   logic [3:0][16:0]   prod_a_ff, prod_a_in;
   logic [SIDE_W-1:0]  side_a_ff;

   // stage B
   lpb_tag_type        tag_b_ff;
   logic [31:0]        acc_b_ff, acc_b_in;
   logic [SIDE_W-1:0]  side_b_ff;

   logic [7:0] oa, na, wgt;
   logic [3:0][7:0] o_ch, n_ch, wo_ch, wn_ch, bias_ch;

   always_comb begin
      oa  = in_acc[31:24];
      na  = in_px[31:24];
      wgt = (ctrl.mode == MODE_MIX) ? ctrl.mix_weight : na;
      tag_a_in.valid = in_tag.valid;
      tag_a_in.have  = in_tag.have | layer_en;
      for (int k = 0; k < 4; k++) begin
         o_ch[k]        = in_acc[8*k +: 8];
         n_ch[k]        = in_px[8*k +: 8];
         wo_ch[k]       = '0;
         wn_ch[k]       = '0;
         bias_ch[k]     = '0;
         sel_a_in[k]    = 1'b0;
         simple_a_in[k] = o_ch[k];
         if (!layer_en) begin
            simple_a_in[k] = o_ch[k];
         end else if (!in_tag.have) begin
            simple_a_in[k] = n_ch[k];
         end else begin
            unique case (ctrl.mode)
               MODE_ADD: begin
                  if (k == 3) begin
                     simple_a_in[k] = (oa > na) ? oa : na;
                  end else begin
                     sel_a_in[k] = 1'b1;
                     wo_ch[k]    = oa;
                     wn_ch[k]    = na;
                  end
               end
               MODE_ALPHA, MODE_MIX: begin
                  sel_a_in[k] = 1'b1;
                  wo_ch[k]    = CH_MAX - wgt;
                  wn_ch[k]    = wgt;
                  bias_ch[k]  = LERP_BIAS;
               end
               MODE_SUB: simple_a_in[k] = (n_ch[k] > o_ch[k]) ? n_ch[k] - o_ch[k] : 8'd0;
               MODE_MAX: simple_a_in[k] = (n_ch[k] > o_ch[k]) ? n_ch[k] : o_ch[k];
               MODE_MIN: simple_a_in[k] = (n_ch[k] < o_ch[k]) ? n_ch[k] : o_ch[k];
               default:  simple_a_in[k] = o_ch[k];
            endcase
         end
         prod_a_in[k] = ({9'b0, o_ch[k]} * {9'b0, wo_ch[k]})
                      + ({9'b0, n_ch[k]} * {9'b0, wn_ch[k]})
                      + {9'b0, bias_ch[k]};
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc_b_in[8*k +: 8] = sel_a_ff[k] ? div255(prod_a_ff[k]) : simple_a_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
      end else if (adv) begin
         tag_a_ff <= tag_a_in;
         tag_b_ff <= tag_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         simple_a_ff <= simple_a_in;
         sel_a_ff    <= sel_a_in;
         prod_a_ff   <= prod_a_in;
         side_a_ff   <= in_side;
         acc_b_ff    <= acc_b_in;
         side_b_ff   <= side_a_ff;
      end
   end

   assign out_tag  = tag_b_ff;
   assign out_acc  = acc_b_ff;
   assign out_side = side_b_ff;

endmodule

// ----- rtl/core/layer_pixel_blend_core.sv -----
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  four ARGB layer pixels, frame end mark
// rsp      out        rsp_valid/rsp_stall  blended pixel, pixel valid, frame end
// csr      in         csr_valid/csr_ready  register index, write data
//
// One pixel per clock sustained while the skid is empty; from req acceptance
// to rsp_valid it passes the input stage, three 2-stage blend steps, output register.
// Each blend step is a multiply stage followed by a divide-by-255 stage.
// Reset is synchronous: valids clear, registers return to add mode,
// all layers enabled, mix weight 128.
// A stalled output fills a one-entry skid; the pipeline freezes while it is
// full, so req_stall is a register and nothing is dropped or repeated.
`include "layer_pixel_blend_core_assert.svh"

module layer_pixel_blend_core (
   input  logic                  clock,
   input  logic                  reset,
   // input transactions
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_layer_a_pixel,
   input  logic [31:0]           req_layer_b_pixel,
   input  logic [31:0]           req_layer_c_pixel,
   input  logic [31:0]           req_layer_d_pixel,
   input  logic                  req_frame_end_in,
   // result transactions
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_blended_pixel,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_frame_end_out,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lpb_pkg::csr_addr_type csr_index,
   input  logic [7:0]            csr_data
);
   import lpb_pkg::*;

   // side payload widths: later layer pixels plus the frame end mark
   localparam int SIDE1_W = 2 * 32 + 1;
   localparam int SIDE2_W = 32 + 1;
   localparam int SIDE3_W = 1;

   // ---------------- configuration registers ----------------
   logic [2:0]            mode_ff;
   logic [NUM_LAYERS-1:0] enable_ff;
   logic [7:0]            mix_weight_ff;
   lpb_ctrl_type          ctrl;

   assign csr_ready = 1'b1;   // writes always taken

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= RST_BLEND_MODE;
         enable_ff     <= RST_LAYER_ENABLE;
         mix_weight_ff <= RST_MIX_WEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLEND_MODE:   mode_ff       <= csr_data[2:0];
            CSR_LAYER_ENABLE: enable_ff     <= csr_data[NUM_LAYERS-1:0];
            CSR_MIX_WEIGHT:   mix_weight_ff <= csr_data;
            default: ;        // index beyond the list: ignored
         endcase
      end
   end

   assign ctrl.mode       = mode_ff;
   assign ctrl.mix_weight = mix_weight_ff;

   // ---------------- pipeline advance / flow control ----------------
   logic pipe_adv;
   logic skid_valid_ff;
   logic out_valid_ff;
   logic out_free;

   assign pipe_adv  = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // ---------------- input stage: layer a becomes the base ----------------
   lpb_tag_type        s0_tag_ff;
   logic [31:0]        s0_acc_ff;
   logic [31:0]        s0_px_ff;
   logic [SIDE1_W-1:0] s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
      end else if (pipe_adv) begin
         s0_tag_ff.valid <= req_valid;
         s0_tag_ff.have  <= enable_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s0_acc_ff  <= enable_ff[0] ? req_layer_a_pixel : 32'd0;
         s0_px_ff   <= req_layer_b_pixel;
         s0_side_ff <= {req_layer_d_pixel, req_layer_c_pixel, req_frame_end_in};
      end
   end

   // ---------------- blend steps for layers b, c, d ----------------
   lpb_tag_type        s1_tag, s2_tag, s3_tag;
   logic [31:0]        s1_acc, s2_acc, s3_acc;
   logic [SIDE1_W-1:0] s1_side;
   logic [SIDE2_W-1:0] s2_side;
   logic [SIDE3_W-1:0] s3_side;

   lpb_blend_step #(.SIDE_W(SIDE1_W)) u_step_b (
      .clock    (clock),
      .reset    (reset),
      .adv      (pipe_adv),
      .ctrl     (ctrl),
      .layer_en (enable_ff[1]),
      .in_tag   (s0_tag_ff),
      .in_acc   (s0_acc_ff),
      .in_px    (s0_px_ff),
      .in_side  (s0_side_ff),
      .out_tag  (s1_tag),
      .out_acc  (s1_acc),
      .out_side (s1_side)
   );

   lpb_blend_step #(.SIDE_W(SIDE2_W)) u_step_c (
      .clock    (clock),
      .reset    (reset),
      .adv      (pipe_adv),
      .ctrl     (ctrl),
      .layer_en (enable_ff[2]),
      .in_tag   (s1_tag),
      .in_acc   (s1_acc),
      .in_px    (s1_side[32:1]),
      .in_side  ({s1_side[64:33], s1_side[0]}),
      .out_tag  (s2_tag),
      .out_acc  (s2_acc),
      .out_side (s2_side)
   );

   lpb_blend_step #(.SIDE_W(SIDE3_W)) u_step_d (
      .clock    (clock),
      .reset    (reset),
      .adv      (pipe_adv),
      .ctrl     (ctrl),
      .layer_en (enable_ff[3]),
      .in_tag   (s2_tag),
      .in_acc   (s2_acc),
      .in_px    (s2_side[32:1]),
      .in_side  (s2_side[0]),
      .out_tag  (s3_tag),
      .out_acc  (s3_acc),
      .out_side (s3_side)
   );

   // ---------------- output register and skid ----------------
   logic        tail_valid;
   logic [31:0] tail_pixel;

   // no layer enabled: accumulator never loaded, so it is already zero
   assign tail_valid = s3_tag.valid;
   assign tail_pixel = s3_acc;

   logic [31:0] out_pixel_ff, skid_pixel_ff;
   logic        out_pv_ff, skid_pv_ff;
   logic        out_fe_ff, skid_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (tail_valid) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_pixel_ff <= skid_pixel_ff;
            out_pv_ff    <= skid_pv_ff;
            out_fe_ff    <= skid_fe_ff;
         end
      end else if (tail_valid) begin
         if (out_free) begin
            out_pixel_ff <= tail_pixel;
            out_pv_ff    <= s3_tag.have;
            out_fe_ff    <= s3_side[0];
         end else begin
            skid_pixel_ff <= tail_pixel;
            skid_pv_ff    <= s3_tag.have;
            skid_fe_ff    <= s3_side[0];
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blended_pixel = out_pixel_ff;
   assign rsp_pixel_valid   = out_pv_ff;
   assign rsp_frame_end_out = out_fe_ff;

   // ---------------- assertions ----------------
   `LPB_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid holds data while output register is empty")
   `LPB_ASSERT_NEXT(a_skid_catches_tail, clock, reset, pipe_adv && tail_valid && out_valid_ff && rsp_stall, skid_valid_ff, "stalled tail transaction not caught by skid")
   `LPB_ASSERT_NOW(a_invalid_pixel_zero, clock, reset, out_valid_ff && !out_pv_ff, out_pixel_ff == 32'd0, "pixel not zero with no enabled layer")
   `LPB_ASSERT_NEXT(a_frozen_holds_tail, clock, reset, skid_valid_ff && !out_free, $stable(s3_acc) && $stable(s3_tag), "pipeline tail moved while frozen")

endmodule
